/* rtl/smt_pkg.sv */
package smt_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_BITS = 32;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int COUNT_OUT_W = 5;
  localparam int REQ_W = 2;
  localparam int IN_DATA_W = ((KEY_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = 8;

  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic load;
    logic match;
    logic commit;
  } cmd_t;

endpackage

/* rtl/smt_ctrl.sv */
module smt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output smt_pkg::cmd_t cmd
);

  smt_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    cmd.load   = 1'b0;
    cmd.match  = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      smt_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = smt_pkg::ST_MATCH;
        end
      end
      smt_pkg::ST_MATCH: begin
        cmd.match = 1'b1;
        state_nxt = smt_pkg::ST_UPDATE;
      end
      smt_pkg::ST_UPDATE: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          in_tready  = 1'b1;
          if (in_tvalid) begin
            cmd.load  = 1'b1;
            state_nxt = smt_pkg::ST_MATCH;
          end else begin
            state_nxt = smt_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = smt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule

/* rtl/smt_dpath.sv */
module smt_dpath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  smt_pkg::cmd_t                   cmd,
  input  logic [smt_pkg::REQ_W-1:0]       req_in,
  input  logic [smt_pkg::KEY_BITS-1:0]    key_in,
  output logic                            was_present,
  output logic [smt_pkg::COUNT_OUT_W-1:0] entry_count,
  output logic                            dropped
);

  logic [smt_pkg::KEY_BITS-1:0]    store_r [smt_pkg::CAPACITY];
  logic [smt_pkg::KEY_BITS-1:0]    key_r;
  logic [smt_pkg::REQ_W-1:0]       req_r;
  logic [smt_pkg::CAPACITY-1:0]    hit_r, hit_nxt;
  logic [smt_pkg::CAPACITY-1:0]    shift_en;
  logic [smt_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic                            was_present_r;
  logic [smt_pkg::COUNT_OUT_W-1:0] entry_count_r;
  logic                            dropped_r;
  logic [smt_pkg::CNT_W+smt_pkg::COUNT_OUT_W-1:0] count_wide;

  logic hit, full, is_ins, is_rem, do_ins, do_rem, drop;

  // parallel compare against the live entries
  always_comb begin
    for (int i = 0; i < smt_pkg::CAPACITY; i++) begin
      hit_nxt[i] = (store_r[i] == key_r) && (smt_pkg::CNT_W'(i) < count_r);
    end
  end

  // entries at or above the hit move down by one
  always_comb begin
    for (int i = 0; i < smt_pkg::CAPACITY; i++) begin
      shift_en[i] = |(hit_r & ~({smt_pkg::CAPACITY{1'b1}} << (i + 1)));
    end
  end

  assign hit    = |hit_r;
  assign full   = (count_r == smt_pkg::CNT_W'(smt_pkg::CAPACITY));
  assign is_ins = (req_r == smt_pkg::REQ_INSERT);
  assign is_rem = (req_r == smt_pkg::REQ_REMOVE);
  assign do_ins = is_ins && !hit && !full;
  assign do_rem = is_rem && hit;
  assign drop   = is_ins && !hit && full;

  always_comb begin
    priority if (do_ins) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rem) begin
      count_nxt = count_r - 1'b1;
    end else begin
      count_nxt = count_r;
    end
  end

  assign count_wide = {{smt_pkg::COUNT_OUT_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= key_in;
      req_r <= req_in;
    end
    if (cmd.match) begin
      hit_r <= hit_nxt;
    end
    if (cmd.commit) begin
      was_present_r <= hit;
      entry_count_r <= count_wide[smt_pkg::COUNT_OUT_W-1:0];
      dropped_r     <= drop;
      if (do_ins) begin
        store_r[count_r[smt_pkg::IDX_W-1:0]] <= key_r;
      end
      if (do_rem) begin
        for (int i = 0; i < smt_pkg::CAPACITY - 1; i++) begin
          if (shift_en[i]) begin
            store_r[i] <= store_r[i+1];
          end
        end
      end
    end
  end

  assign was_present = was_present_r;
  assign entry_count = entry_count_r;
  assign dropped     = dropped_r;

endmodule

/* rtl/set_membership_table_top.sv */
// Channel | Direction | tdata (low bit up)                     | tuser
// in_     | slave     | key                                    | req_type
// out_    | master    | was_present, entry_count, dropped, pad | -
//
// One request passes a compare step over all entries, then an update step that
// writes or shifts the store and loads the output register.
// A new request is taken in the update cycle of the previous one.
// A stalled output holds the update cycle until the result register frees.
// rst_n empties the set; stored keys themselves are not cleared.
module set_membership_table_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [smt_pkg::IN_DATA_W-1:0]  in_tdata,  // key
  input  logic [smt_pkg::REQ_W-1:0]      in_tuser,  // req_type
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [smt_pkg::OUT_DATA_W-1:0] out_tdata  // was_present, entry_count, dropped
);

  smt_pkg::cmd_t                   cmd;
  logic                            was_present;
  logic [smt_pkg::COUNT_OUT_W-1:0] entry_count;
  logic                            dropped;

  smt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  smt_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .req_in      (in_tuser),
    .key_in      (in_tdata[smt_pkg::KEY_BITS-1:0]),
    .was_present (was_present),
    .entry_count (entry_count),
    .dropped     (dropped)
  );

  assign out_tdata = {1'b0, dropped, entry_count, was_present};

endmodule

/* bench/tb_set_membership_table_top.sv */
`timescale 1ns / 100ps

module tb_set_membership_table_top;

  localparam logic [smt_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic             was_present;
    logic [4:0]       entry_count;
    logic             dropped;
  } lookup_result_t;

  class membership_board;
    logic [smt_pkg::KEY_BITS-1:0] keys [smt_pkg::CAPACITY];
    int unsigned                  occupancy;
    lookup_result_t               expected_q [$];
    int                           errors;
    int                           requests;
    int                           results;
    int                           hits;
    int                           drops;
    int unsigned                  peak;

    function new();
      occupancy = 0;
      errors    = 0;
      requests  = 0;
      results   = 0;
      hits      = 0;
      drops     = 0;
      peak      = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // table update for one accepted request
    function void note_request(logic [smt_pkg::REQ_W-1:0]     req,
                               logic [smt_pkg::IN_DATA_W-1:0] data);
      logic [smt_pkg::KEY_BITS-1:0] key;
      lookup_result_t               r;
      int                           at;
      bit                           hit;
      key = data[smt_pkg::KEY_BITS-1:0];
      hit = 0;
      at  = 0;
      r.dropped = 1'b0;
      for (int i = 0; i < occupancy; i++) begin
        if (!hit && keys[i] == key) begin
          hit = 1;
          at  = i;
        end
      end
      if (req == smt_pkg::REQ_INSERT) begin
        if (!hit) begin
          if (occupancy < smt_pkg::CAPACITY) begin
            keys[occupancy] = key;
            occupancy++;
          end else begin
            r.dropped = 1'b1;
          end
        end
      end else if (req == smt_pkg::REQ_REMOVE) begin
        if (hit) begin
          for (int i = at; i + 1 < occupancy; i++) keys[i] = keys[i + 1];
          occupancy--;
        end
      end
      r.was_present = hit;
      r.entry_count = occupancy[4:0];
      expected_q.push_back(r);
      requests++;
      if (occupancy > peak) peak = occupancy;
    endfunction

    task report_mismatch(string what, int got, int want);
      errors++;
      $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task check_result(logic [smt_pkg::OUT_DATA_W-1:0] data);
      lookup_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transfer", 1, 0);
      end else begin
        want = expected_q.pop_front();
        results++;
        if (data[0] !== want.was_present)
          report_mismatch("was_present", data[0], want.was_present);
        if (data[5:1] !== want.entry_count)
          report_mismatch("entry_count", data[5:1], want.entry_count);
        if (data[6] !== want.dropped)
          report_mismatch("dropped", data[6], want.dropped);
        if (want.was_present) hits++;
        if (want.dropped) drops++;
      end
    endtask
  endclass

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [smt_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic [smt_pkg::REQ_W-1:0]      in_tuser   = smt_pkg::REQ_LOOKUP;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [smt_pkg::OUT_DATA_W-1:0] out_tdata;

  int                             send_idle_pct = 0;
  int                             recv_idle_pct = 0;
  logic [smt_pkg::KEY_BITS-1:0]   key_pool [24];
  membership_board                board = new();

  set_membership_table_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // output checked before the input is noted, so ordering stays fixed
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) board.check_result(out_tdata);
      if (in_tvalid && in_tready) board.note_request(in_tuser, in_tdata);
    end
  end

  task send_request(logic [smt_pkg::REQ_W-1:0] req, logic [smt_pkg::KEY_BITS-1:0] key);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= smt_pkg::IN_DATA_W'(key);
    in_tuser  <= req;
    do @(posedge clk); while (!in_tready);
  endtask

  task run_directed();
    send_request(smt_pkg::REQ_LOOKUP, 32'h0000_0000);
    send_request(smt_pkg::REQ_REMOVE, 32'hFFFF_FFFF);
    send_request(smt_pkg::REQ_INSERT, 32'h0000_0000);
    send_request(smt_pkg::REQ_INSERT, 32'hFFFF_FFFF);
    send_request(smt_pkg::REQ_INSERT, 32'h0000_0000);
    send_request(smt_pkg::REQ_LOOKUP, 32'hFFFF_FFFF);
    send_request(REQ_UNUSED, 32'h0000_0000);
    for (int k = 1; k <= smt_pkg::CAPACITY - 2; k++)
      send_request(smt_pkg::REQ_INSERT, k * 32'h9E37_79B9);
    send_request(smt_pkg::REQ_INSERT, 32'h5555_AAAA);
    send_request(smt_pkg::REQ_INSERT, 32'hFFFF_FFFF);
    send_request(smt_pkg::REQ_REMOVE, 5 * 32'h9E37_79B9);
    send_request(smt_pkg::REQ_REMOVE, 32'h0000_0000);
    send_request(smt_pkg::REQ_REMOVE, (smt_pkg::CAPACITY - 2) * 32'h9E37_79B9);
    send_request(smt_pkg::REQ_REMOVE, 32'hAAAA_5555);
    send_request(smt_pkg::REQ_LOOKUP, 6 * 32'h9E37_79B9);
  endtask

  // bursts alternate between filling and draining so both empty and full are hit
  task run_random(int count);
    int                           pick;
    int                           ins_pct;
    logic [smt_pkg::KEY_BITS-1:0] key;
    for (int i = 0; i < count; i++) begin
      ins_pct = ((i / 30) % 2 == 0) ? 60 : 20;
      key  = key_pool[$urandom_range(0, 23)];
      pick = $urandom_range(0, 99);
      if (pick < 8)
        send_request(smt_pkg::REQ_W'($urandom_range(0, 3)), $urandom);
      else if (pick < 8 + ins_pct)
        send_request(smt_pkg::REQ_INSERT, key);
      else if (pick < 85)
        send_request(smt_pkg::REQ_REMOVE, key);
      else if (pick < 96)
        send_request(smt_pkg::REQ_LOOKUP, key);
      else
        send_request(REQ_UNUSED, key);
    end
  endtask

  initial begin
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 24; i++) key_pool[i] = $urandom;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 35;
    recv_idle_pct = 88;
    run_directed();
    run_random(150);
    send_idle_pct = 88;
    recv_idle_pct = 35;
    run_random(150);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(150);
    in_tvalid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("requests %0d, results %0d, hits %0d, dropped inserts %0d",
             board.requests, board.results, board.hits, board.drops);
    $display("peak occupancy %0d of %0d, mismatches %0d", board.peak, smt_pkg::CAPACITY,
             board.errors);
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d transfers outstanding", board.pending());
    $display("== FAIL ==");
    $finish;
  end

endmodule
